/* sv/sfs_pkg.sv */
// ----------------------------------------------------------------------------
// sfs_pkg
// Types and constants shared by the sprite frame sequencer and its channels.
// ----------------------------------------------------------------------------
package sfs_pkg;

   localparam int MAX_FRAMES = 256;
   localparam int FRAME_CAP  = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;

   localparam int ELAPSED_W = 16;
   localparam int FRAME_W   = 8;
   localparam int COUNT_W   = 9;
   localparam int PERIOD_W  = 24;
   localparam int CD_W      = PERIOD_W + 1;
   localparam int MODE_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = PERIOD_W;

   localparam logic [COUNT_W-1:0] FRAME_CAP_C = COUNT_W'(FRAME_CAP);

   typedef enum logic [MODE_W-1:0] {
      MODE_ONCE          = 2'd0,
      MODE_RESTART       = 2'd1,
      MODE_PINGPONG      = 2'd2,
      MODE_PINGPONG_ONCE = 2'd3
   } repeat_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_COUNT  = 2'd0,
      CSR_FRAME_PERIOD = 2'd1,
      CSR_REPEAT_MODE  = 2'd2,
      CSR_PAUSE        = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_index;
      logic               backward;
      logic               finished;
      logic               stepped;
   } result_type;

endpackage

/* sv/sfs_req_if.sv */
// ----------------------------------------------------------------------------
// sfs_req_if
// Tick request channel: valid/ready handshake carrying the elapsed time.
// ----------------------------------------------------------------------------
interface sfs_req_if;
   logic                           valid;
   logic                           ready;
   logic [sfs_pkg::ELAPSED_W-1:0]  elapsed;

   modport source (output valid, output elapsed, input ready);
   modport sink   (input valid, input elapsed, output ready);
endinterface

/* sv/sfs_rsp_if.sv */
// ----------------------------------------------------------------------------
// sfs_rsp_if
// Result channel: valid/ready handshake carrying the frame state of one tick.
// ----------------------------------------------------------------------------
interface sfs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sfs_pkg::FRAME_W-1:0]   frame_index;
   logic                          backward;
   logic                          finished;
   logic                          stepped;

   modport source (output valid, output frame_index, output backward,
                   output finished, output stepped, input ready);
   modport sink   (input valid, input frame_index, input backward,
                   input finished, input stepped, output ready);
endinterface

/* sv/sprite_frame_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_unit
// Sprite animation frame sequencer with once, restart, ping-pong and ping-pong-once modes.
// ----------------------------------------------------------------------------
// Each tick request passes two registers from acceptance to result: the input
// register, then the result register. The countdown subtract, expiry compare
// and frame step are combinational between the two, so one request is taken
// every clock cycle unless the response channel stalls; the input register keeps
// taking requests while a result waits on a stalled response channel, until both stages are full.
module sprite_frame_sequencer_unit (
   input  logic                            clock,
   input  logic                            reset,
   sfs_req_if.sink                         req,
   sfs_rsp_if.source                       rsp,
   input  logic                            csr_we,
   input  logic [sfs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sfs_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import sfs_pkg::*;

   logic [COUNT_W-1:0]   frame_count_ff;
   logic [PERIOD_W-1:0]  frame_period_ff;
   repeat_mode_type      repeat_mode_ff;
   logic                 pause_ff;

   logic [CD_W-1:0]      countdown_ff, countdown_in;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   logic                 reverse_ff, reverse_in;
   logic                 ended_ff, ended_in;

   logic                 in_valid_ff;
   logic [ELAPSED_W-1:0] in_elapsed_ff;
   logic                 out_valid_ff;
   result_type           out_ff, out_in;

   logic                 move;
   logic                 active;
   logic                 expire;
   logic [CD_W-1:0]      diff;
   logic [FRAME_W-1:0]   last;
   logic [COUNT_W-1:0]   next;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff  <= COUNT_W'(1);
         frame_period_ff <= PERIOD_W'(1);
         repeat_mode_ff  <= MODE_ONCE;
         pause_ff        <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_COUNT:  frame_count_ff  <= csr_wdata[COUNT_W-1:0];
            CSR_FRAME_PERIOD: frame_period_ff <= csr_wdata[PERIOD_W-1:0];
            CSR_REPEAT_MODE:  repeat_mode_ff  <= repeat_mode_type'(csr_wdata[MODE_W-1:0]);
            CSR_PAUSE:        pause_ff        <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign move      = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || move;

   always_comb begin
      if (frame_count_ff == '0) begin
         last = '0;
      end else if (frame_count_ff > FRAME_CAP_C) begin
         last = FRAME_W'(FRAME_CAP_C - COUNT_W'(1));
      end else begin
         last = FRAME_W'(frame_count_ff - COUNT_W'(1));
      end
   end

   always_comb begin
      active = !ended_ff && !pause_ff;
      diff   = countdown_ff - {{(CD_W-ELAPSED_W){1'b0}}, in_elapsed_ff};
      expire = active && (diff[CD_W-1] || (diff == '0));
      next   = {1'b0, frame_ff} + COUNT_W'(1);

      countdown_in = countdown_ff;
      frame_in     = frame_ff;
      reverse_in   = reverse_ff;
      ended_in     = ended_ff;

      if (expire) begin
         countdown_in = {1'b0, frame_period_ff};
         if (!reverse_ff) begin
            if (next > {1'b0, last}) begin
               case (repeat_mode_ff)
                  MODE_ONCE: begin
                     frame_in = last;
                     ended_in = 1'b1;
                  end
                  MODE_RESTART: frame_in = '0;
                  default: begin
                     frame_in   = (last != '0) ? last - FRAME_W'(1) : '0;
                     reverse_in = 1'b1;
                  end
               endcase
            end else begin
               frame_in = next[FRAME_W-1:0];
            end
         end else if (frame_ff == '0) begin
            case (repeat_mode_ff)
               MODE_RESTART: frame_in = last;
               MODE_PINGPONG: begin
                  frame_in   = (last != '0) ? FRAME_W'(1) : last;
                  reverse_in = 1'b0;
               end
               default: begin
                  frame_in = '0;
                  ended_in = 1'b1;
               end
            endcase
         end else begin
            frame_in = frame_ff - FRAME_W'(1);
         end
      end else if (active) begin
         countdown_in = diff;
      end

      out_in.frame_index = frame_in;
      out_in.backward    = reverse_in;
      out_in.finished    = ended_in;
      out_in.stepped     = expire;
   end

   // sequencer state and pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= '0;
         frame_ff     <= '0;
         reverse_ff   <= 1'b0;
         ended_ff     <= 1'b0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (move) begin
            countdown_ff <= countdown_in;
            frame_ff     <= frame_in;
            reverse_ff   <= reverse_in;
            ended_ff     <= ended_in;
         end
         if (req.valid && req.ready) begin
            in_valid_ff <= 1'b1;
         end else if (move) begin
            in_valid_ff <= 1'b0;
         end
         if (move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_elapsed_ff <= req.elapsed;
      end
      if (move) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.frame_index = out_ff.frame_index;
   assign rsp.backward    = out_ff.backward;
   assign rsp.finished    = out_ff.finished;
   assign rsp.stepped     = out_ff.stepped;

   a_ended_sticky: assert property (@(posedge clock) disable iff (reset)
      ended_ff |=> ended_ff)
      else $error("ended flag cleared without reset");

   a_countdown_nonneg: assert property (@(posedge clock) disable iff (reset)
      !countdown_ff[CD_W-1])
      else $error("stored countdown went negative");

   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !move |=> in_valid_ff && $stable(in_elapsed_ff))
      else $error("stalled tick lost from input register");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      move |=> out_valid_ff)
      else $error("result register not loaded after move");

endmodule

/* dv/tb_sprite_frame_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// tb_sprite_frame_sequencer_unit
// Drives tick requests with random elapsed times through the sequencer while
// stepping frame count, period, repeat mode and pause between phases. An
// in-bench frame predictor follows the countdown, direction and end flag,
// and every result is checked field by field in order. The run closes on one
// of the three ways a one-shot sequence ends, since only reset clears it.
// ----------------------------------------------------------------------------
module tb_sprite_frame_sequencer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import sfs_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int TICK_TARGET = 1750;

   typedef enum logic {ROW_CSR, ROW_TICK} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      csr_index_type        reg_index;
      logic [CSR_DAT_W-1:0] value;
      bit                   typed;
      result_type           want;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   sfs_req_if req_ch ();
   sfs_rsp_if rsp_ch ();

   sprite_frame_sequencer_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register shadow
   logic [COUNT_W-1:0]  frame_count_q;
   logic [PERIOD_W-1:0] frame_period_q;
   repeat_mode_type     mode_q;
   logic                pause_q;

   // predicted sequencer state
   int                  countdown_q;
   logic [FRAME_W-1:0]  frame_q;
   logic                reverse_q;
   logic                ended_q;

   result_type          pending_frames[$];
   int                  fail_count  = 0;
   int                  cycle_count = 0;
   int                  ticks_sent  = 0;
   int                  step_count  = 0;
   int                  stall_left  = 0;
   bit                  idle_on     = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int end_frame();
      int n;
      n = int'(frame_count_q);
      if (n == 0) n = 1;
      if (n > FRAME_CAP) n = FRAME_CAP;
      return n - 1;
   endfunction

   function automatic void step_frame();
      int top;
      int nxt;
      top = end_frame();
      if (!reverse_q) begin
         nxt = int'(frame_q) + 1;
         if (nxt > top) begin
            case (mode_q)
               MODE_ONCE: begin
                  frame_q = FRAME_W'(top);
                  ended_q = 1'b1;
               end
               MODE_RESTART: begin
                  frame_q = '0;
               end
               default: begin
                  frame_q   = FRAME_W'((top >= 1) ? top - 1 : 0);
                  reverse_q = 1'b1;
               end
            endcase
         end else begin
            frame_q = FRAME_W'(nxt);
         end
      end else if (frame_q == '0) begin
         case (mode_q)
            MODE_RESTART: begin
               frame_q = FRAME_W'(top);
            end
            MODE_PINGPONG: begin
               frame_q   = FRAME_W'((top >= 1) ? 1 : top);
               reverse_q = 1'b0;
            end
            default: begin
               frame_q = '0;
               ended_q = 1'b1;
            end
         endcase
      end else begin
         frame_q = frame_q - FRAME_W'(1);
      end
   endfunction

   function automatic result_type predict_tick(logic [ELAPSED_W-1:0] elapsed);
      result_type r;
      r.stepped = 1'b0;
      if (!ended_q && !pause_q) begin
         countdown_q = countdown_q - int'(elapsed);
         if (countdown_q <= 0) begin
            countdown_q = int'(frame_period_q);
            r.stepped   = 1'b1;
            step_frame();
         end
      end
      r.frame_index = frame_q;
      r.backward    = reverse_q;
      r.finished    = ended_q;
      return r;
   endfunction

   // long countdowns get drained quickly so later phases still step frames
   function automatic logic [ELAPSED_W-1:0] pick_elapsed();
      if (countdown_q > 70000 && $urandom_range(0, 3) != 0) return '1;
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return ELAPSED_W'($urandom);
         default: return ELAPSED_W'($urandom_range(0, 15));
      endcase
   endfunction

   task automatic report(string msg);
      $display("t=%0t %s", $time, msg);
      fail_count++;
   endtask

   // bits above the register width carry noise; the block keeps only the low bits
   task automatic write_csr(csr_index_type reg_index, logic [CSR_DAT_W-1:0] value);
      logic [CSR_DAT_W-1:0] word;
      word = CSR_DAT_W'($urandom);
      case (reg_index)
         CSR_FRAME_COUNT: begin
            frame_count_q        = value[COUNT_W-1:0];
            word[COUNT_W-1:0]    = value[COUNT_W-1:0];
         end
         CSR_FRAME_PERIOD: begin
            frame_period_q = value;
            word           = value;
         end
         CSR_REPEAT_MODE: begin
            mode_q            = repeat_mode_type'(value[MODE_W-1:0]);
            word[MODE_W-1:0]  = value[MODE_W-1:0];
         end
         CSR_PAUSE: begin
            pause_q = value[0];
            word[0] = value[0];
         end
      endcase
      csr_we    <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= word;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_tick(logic [ELAPSED_W-1:0] elapsed, bit typed, result_type want);
      result_type r;
      bit         taken;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.elapsed <= elapsed;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_ch.ready;
         if (taken) begin
            r = predict_tick(elapsed);
            if (r.stepped) step_count++;
            pending_frames.push_back(typed ? want : r);
         end
         @(posedge clock);
      end
      ticks_sent++;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_frames.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left   <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left   <= $urandom_range(0, 15);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // values seen at the falling edge are the ones the next rising edge takes
   always @(negedge clock) begin
      result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_frames.size() == 0) begin
            report($sformatf("result frame %0d with no request pending",
                             rsp_ch.frame_index));
         end else begin
            want = pending_frames.pop_front();
            if (rsp_ch.frame_index !== want.frame_index)
               report($sformatf("frame_index %0d, expected %0d",
                                rsp_ch.frame_index, want.frame_index));
            if (rsp_ch.backward !== want.backward)
               report($sformatf("backward %0b, expected %0b",
                                rsp_ch.backward, want.backward));
            if (rsp_ch.finished !== want.finished)
               report($sformatf("finished %0b, expected %0b",
                                rsp_ch.finished, want.finished));
            if (rsp_ch.stepped !== want.stepped)
               report($sformatf("stepped %0b, expected %0b",
                                rsp_ch.stepped, want.stepped));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sprite_frame_sequencer_unit: mismatch");
         $finish;
      end
   end

   initial begin
      stim_row_type         rows[$];
      int                   phase_len;
      int                   sel;
      int                   start_steps;
      bit                   pause_now;
      bit                   want_back;
      repeat_mode_type      mode_pick;
      repeat_mode_type      end_mode;
      logic [CSR_DAT_W-1:0] word;

      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= CSR_FRAME_COUNT;
      csr_wdata      <= '0;
      req_ch.valid   <= 1'b0;
      req_ch.elapsed <= '0;

      frame_count_q  = COUNT_W'(1);
      frame_period_q = PERIOD_W'(1);
      mode_q         = MODE_ONCE;
      pause_q        = 1'b0;
      countdown_q    = 0;
      frame_q        = '0;
      reverse_q      = 1'b0;
      ended_q        = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // want = {frame_index, backward, finished, stepped}
      rows = '{
         '{ROW_CSR,  CSR_PAUSE,        24'd1,        1'b0, '0},
         '{ROW_TICK, CSR_FRAME_COUNT,  24'd65535,    1'b1, {8'd0, 1'b0, 1'b0, 1'b0}},
         '{ROW_CSR,  CSR_PAUSE,        24'd0,        1'b0, '0},
         '{ROW_CSR,  CSR_REPEAT_MODE,  CSR_DAT_W'(MODE_RESTART), 1'b0, '0},
         '{ROW_TICK, CSR_FRAME_COUNT,  24'd0,        1'b1, {8'd0, 1'b0, 1'b0, 1'b1}},
         '{ROW_TICK, CSR_FRAME_COUNT,  24'd0,        1'b1, {8'd0, 1'b0, 1'b0, 1'b0}},
         '{ROW_TICK, CSR_FRAME_COUNT,  24'd1,        1'b1, {8'd0, 1'b0, 1'b0, 1'b1}},
         '{ROW_CSR,  CSR_FRAME_COUNT,  24'd4,        1'b0, '0},
         '{ROW_CSR,  CSR_FRAME_PERIOD, 24'd3,        1'b0, '0},
         '{ROW_TICK, CSR_FRAME_COUNT,  24'd1,        1'b0, '0},
         '{ROW_TICK, CSR_FRAME_COUNT,  24'd1,        1'b0, '0},
         '{ROW_TICK, CSR_FRAME_COUNT,  24'd1,        1'b0, '0},
         '{ROW_TICK, CSR_FRAME_COUNT,  24'd2,        1'b0, '0},
         '{ROW_CSR,  CSR_FRAME_COUNT,  24'd0,        1'b0, '0},
         '{ROW_TICK, CSR_FRAME_COUNT,  24'd65535,    1'b0, '0},
         '{ROW_CSR,  CSR_REPEAT_MODE,  CSR_DAT_W'(MODE_PINGPONG), 1'b0, '0},
         '{ROW_CSR,  CSR_FRAME_COUNT,  24'd3,        1'b0, '0},
         '{ROW_CSR,  CSR_FRAME_PERIOD, 24'd0,        1'b0, '0},
         '{ROW_TICK, CSR_FRAME_COUNT,  24'd3,        1'b0, '0},
         '{ROW_TICK, CSR_FRAME_COUNT,  24'd0,        1'b0, '0},
         '{ROW_TICK, CSR_FRAME_COUNT,  24'd0,        1'b0, '0},
         '{ROW_TICK, CSR_FRAME_COUNT,  24'd0,        1'b0, '0},
         '{ROW_TICK, CSR_FRAME_COUNT,  24'd0,        1'b0, '0},
         '{ROW_TICK, CSR_FRAME_COUNT,  24'd0,        1'b0, '0},
         '{ROW_CSR,  CSR_FRAME_COUNT,  24'd511,      1'b0, '0},
         '{ROW_TICK, CSR_FRAME_COUNT,  24'd0,        1'b0, '0},
         '{ROW_TICK, CSR_FRAME_COUNT,  24'd0,        1'b0, '0},
         '{ROW_CSR,  CSR_FRAME_PERIOD, 24'hFFFFFF,   1'b0, '0},
         '{ROW_TICK, CSR_FRAME_COUNT,  24'd65535,    1'b0, '0},
         '{ROW_TICK, CSR_FRAME_COUNT,  24'd65535,    1'b0, '0},
         '{ROW_CSR,  CSR_REPEAT_MODE,  CSR_DAT_W'(MODE_ONCE), 1'b0, '0},
         '{ROW_TICK, CSR_FRAME_COUNT,  24'd65535,    1'b0, '0},
         '{ROW_CSR,  CSR_REPEAT_MODE,  CSR_DAT_W'(MODE_PINGPONG_ONCE), 1'b0, '0},
         '{ROW_TICK, CSR_FRAME_COUNT,  24'd0,        1'b0, '0}
      };

      idle_on = 1'b1;
      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR) begin
            wait_idle();
            write_csr(rows[i].reg_index, rows[i].value);
         end else begin
            send_tick(rows[i].value[ELAPSED_W-1:0], rows[i].typed, rows[i].want);
         end
      end

      // sweep with 256 frames: up to the top frame and part of the way back
      wait_idle();
      write_csr(CSR_REPEAT_MODE, CSR_DAT_W'(MODE_PINGPONG));
      write_csr(CSR_FRAME_COUNT, 24'd256);
      write_csr(CSR_FRAME_PERIOD, 24'd0);
      write_csr(CSR_PAUSE, 24'd0);
      start_steps = step_count;
      while (step_count - start_steps < 300)
         send_tick({1'b1, 15'($urandom)}, 1'b0, '0);

      // one-shot modes only while paused, so the sequence cannot end early
      while (ticks_sent < TICK_TARGET) begin
         wait_idle();
         idle_on   = (ticks_sent < TICK_TARGET - 200) && ($urandom_range(0, 3) != 0);
         pause_now = ($urandom_range(0, 5) == 0);
         if (pause_now)
            mode_pick = repeat_mode_type'($urandom_range(0, 3));
         else
            mode_pick = $urandom_range(0, 1) ? MODE_PINGPONG : MODE_RESTART;
         if (pause_now) write_csr(CSR_PAUSE, 24'd1);
         write_csr(CSR_REPEAT_MODE, CSR_DAT_W'(mode_pick));
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
               0:       word = 24'd0;
               1:       word = 24'd256;
               2:       word = 24'd511;
               3:       word = CSR_DAT_W'($urandom_range(0, 511));
               default: word = CSR_DAT_W'($urandom_range(1, 8));
            endcase
            write_csr(CSR_FRAME_COUNT, word);
         end
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 19))
               0:          word = 24'd0;
               1:          word = 24'hFFFFFF;
               2:          word = CSR_DAT_W'($urandom_range(70000, 24'hFFFFFF));
               3, 4, 5, 6: word = CSR_DAT_W'($urandom_range(1, 70000));
               default:    word = CSR_DAT_W'($urandom_range(1, 12));
            endcase
            write_csr(CSR_FRAME_PERIOD, word);
         end
         if (!pause_now) write_csr(CSR_PAUSE, 24'd0);
         phase_len = $urandom_range(20, 100);
         repeat (phase_len) send_tick(pick_elapsed(), 1'b0, '0);
      end

      // end the sequence: once forward, once while reversed, or ping-pong once
      wait_idle();
      idle_on   = 1'b0;
      sel       = $urandom_range(0, 2);
      want_back = (sel == 1);
      end_mode  = (sel == 2) ? MODE_PINGPONG_ONCE : MODE_ONCE;
      write_csr(CSR_REPEAT_MODE, CSR_DAT_W'(MODE_PINGPONG));
      write_csr(CSR_FRAME_COUNT, 24'd2);
      write_csr(CSR_FRAME_PERIOD, 24'd0);
      write_csr(CSR_PAUSE, 24'd0);
      while (reverse_q != want_back) send_tick('1, 1'b0, '0);
      wait_idle();
      write_csr(CSR_FRAME_COUNT, CSR_DAT_W'($urandom_range(1, 6)));
      write_csr(CSR_REPEAT_MODE, CSR_DAT_W'(end_mode));
      while (!ended_q) send_tick(ELAPSED_W'($urandom), 1'b0, '0);
      repeat (10) send_tick(pick_elapsed(), 1'b0, '0);

      // a new mode must not revive an ended sequence
      wait_idle();
      write_csr(CSR_REPEAT_MODE, CSR_DAT_W'(MODE_RESTART));
      write_csr(CSR_FRAME_COUNT, 24'd8);
      repeat (10) send_tick(pick_elapsed(), 1'b0, '0);

      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("sprite_frame_sequencer_unit: match");
      end else begin
         $display("sprite_frame_sequencer_unit: mismatch");
      end
      $finish;
   end

endmodule
